@@ rtl/wft_pkg.sv @@
// Shared constants, types and handshake structs of the word frequency block.
package wft_pkg;

	localparam int MAX_WORDS  = 1024;
	localparam int WORD_CHARS = 64;
	localparam int TOP_COUNT  = 10;

	localparam int IDX_W      = $clog2(MAX_WORDS);
	localparam int USED_W     = $clog2(MAX_WORDS + 1);
	localparam int LEN_W      = $clog2(WORD_CHARS + 1);
	localparam int CHAR_IDX_W = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
	localparam int RANK_W     = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

	localparam int KIND_W     = 2;
	localparam int ENTRY_W    = 10;
	localparam int COUNT_W    = 32;
	localparam int RANK_OUT_W = 4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef logic [WORD_CHARS-1:0][7:0] word_row_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_COUNTED = 2'd0,
		KIND_FULL    = 2'd1,
		KIND_RANKED  = 2'd2
	} kind_t;

	localparam logic OP_CHAR   = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	typedef enum logic [1:0] {
		RES_HIT,
		RES_MISS,
		RES_RANK
	} res_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_HIT_OUT,
		ST_MISS_OUT,
		ST_RPT_SCAN,
		ST_RPT_OUT
	} state_t;

	typedef struct packed {
		logic     char_wr;
		logic     scan_clr;
		logic     scan_run;
		logic     rank_clr;
		logic     rank_inc;
		logic     emit;
		res_sel_t res_sel;
	} wft_cmd_t;

	typedef struct packed {
		logic match;
		logic scan_done;
		logic out_free;
		logic rank_last;
	} wft_stat_t;

endpackage

@@ rtl/wft_ctrl.sv @@
// Controller state machine: sequences character writes, table search and report passes.
module wft_ctrl import wft_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  logic      op,
	input  logic      last_char,
	output logic      item_ready,
	input  wft_stat_t stat,
	output wft_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.res_sel = RES_HIT;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (op == OP_REPORT) begin
						cmd.scan_clr = 1'b1;
						cmd.rank_clr = 1'b1;
						state_d      = ST_RPT_SCAN;
					end else begin
						cmd.char_wr = 1'b1;
						if (last_char) begin
							cmd.scan_clr = 1'b1;
							state_d      = ST_SEARCH;
						end
					end
				end
			end
			ST_SEARCH: begin
				cmd.scan_run = 1'b1;
				priority if (stat.match) begin
					state_d = ST_HIT_OUT;
				end else if (stat.scan_done) begin
					state_d = ST_MISS_OUT;
				end
			end
			ST_HIT_OUT: begin
				cmd.res_sel = RES_HIT;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_MISS_OUT: begin
				cmd.res_sel = RES_MISS;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_RPT_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_done) begin
					state_d = ST_RPT_OUT;
				end
			end
			ST_RPT_OUT: begin
				cmd.res_sel = RES_RANK;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.rank_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.rank_inc = 1'b1;
						cmd.scan_clr = 1'b1;
						state_d      = ST_RPT_SCAN;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/wft_dp.sv @@
// Datapath: word buffer, entry memories, scan pipeline and result register.
module wft_dp import wft_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wft_cmd_t              cmd,
	output wft_stat_t             stat,
	input  logic [7:0]            word_char,
	input  logic                  result_ready,
	output logic                  result_valid,
	output logic [KIND_W-1:0]     kind,
	output logic [ENTRY_W-1:0]    entry_index,
	output logic [COUNT_W-1:0]    count,
	output logic [RANK_OUT_W-1:0] rank,
	output logic                  last_result
);

	word_row_t          row_mem [MAX_WORDS];
	logic [LEN_W-1:0]   len_mem [MAX_WORDS];
	logic [COUNT_W-1:0] cnt_mem [MAX_WORDS];

	word_row_t          word_q;
	logic [LEN_W-1:0]   cur_len_q;
	logic [USED_W-1:0]  used_q;
	logic [USED_W-1:0]  scan_idx_q;
	logic               valid_s1;
	logic [IDX_W-1:0]   idx_s1;
	word_row_t          row_s1;
	logic [LEN_W-1:0]   len_s1;
	logic [COUNT_W-1:0] cnt_s1;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [COUNT_W-1:0] hit_cnt_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [COUNT_W-1:0] best_q;
	logic [RANK_W-1:0]  rank_q;

	logic               out_valid_q;
	kind_t              out_kind_q;
	logic [ENTRY_W-1:0] out_idx_q;
	logic [COUNT_W-1:0] out_cnt_q;
	logic [RANK_OUT_W-1:0] out_rank_q;
	logic               out_last_q;

	logic               issue;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   new_addr;
	logic               room;
	logic               bytes_eq;
	logic               match;
	logic               out_free;
	logic [COUNT_W-1:0] hit_next;
	logic               cnt_we;
	logic [IDX_W-1:0]   cnt_waddr;
	logic [COUNT_W-1:0] cnt_wdata;
	logic               row_we;

	assign issue    = cmd.scan_run && (scan_idx_q < used_q);
	assign rd_addr  = scan_idx_q[IDX_W-1:0];
	assign new_addr = used_q[IDX_W-1:0];
	assign room     = used_q < USED_W'(MAX_WORDS);
	assign out_free = !out_valid_q || result_ready;
	assign hit_next = (hit_cnt_q == COUNT_MAX) ? hit_cnt_q : hit_cnt_q + COUNT_W'(1);

	// bytes beyond the current length do not take part in the compare
	always_comb begin
		bytes_eq = 1'b1;
		for (int i = 0; i < WORD_CHARS; i++) begin
			if ((LEN_W'(i) < cur_len_q) && (row_s1[i] != word_q[i])) begin
				bytes_eq = 1'b0;
			end
		end
	end

	assign match = valid_s1 && (len_s1 == cur_len_q) && bytes_eq;

	assign stat.match     = match;
	assign stat.scan_done = !issue && !valid_s1;
	assign stat.out_free  = out_free;
	assign stat.rank_last = rank_q == RANK_W'(TOP_COUNT - 1);

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = hit_idx_q;
		cnt_wdata = hit_next;
		row_we    = 1'b0;
		if (cmd.emit) begin
			unique case (cmd.res_sel)
				RES_HIT: begin
					cnt_we = 1'b1;
				end
				RES_MISS: begin
					cnt_we    = room;
					row_we    = room;
					cnt_waddr = new_addr;
					cnt_wdata = COUNT_W'(1);
				end
				RES_RANK: begin
					cnt_we    = 1'b1;
					cnt_waddr = best_idx_q;
					cnt_wdata = '0;
				end
				default: begin
					cnt_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (row_we) begin
			row_mem[new_addr] <= word_q;
			len_mem[new_addr] <= cur_len_q;
		end
		if (issue) begin
			row_s1 <= row_mem[rd_addr];
			len_s1 <= len_mem[rd_addr];
			cnt_s1 <= cnt_mem[rd_addr];
		end
		idx_s1 <= rd_addr;
	end

	always_ff @(posedge clk) begin
		if (cmd.char_wr && (cur_len_q < LEN_W'(WORD_CHARS))) begin
			word_q[cur_len_q[CHAR_IDX_W-1:0]] <= word_char;
		end
		if (cmd.scan_run && match) begin
			hit_idx_q <= idx_s1;
			hit_cnt_q <= cnt_s1;
		end
		if (cmd.scan_clr) begin
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (cmd.scan_run && valid_s1 && (cnt_s1 > best_q)) begin
			best_q     <= cnt_s1;
			best_idx_q <= idx_s1;
		end
		if (cmd.emit) begin
			unique case (cmd.res_sel)
				RES_HIT: begin
					out_kind_q <= KIND_COUNTED;
					out_idx_q  <= ENTRY_W'(hit_idx_q);
					out_cnt_q  <= hit_next;
					out_rank_q <= '0;
					out_last_q <= 1'b1;
				end
				RES_MISS: begin
					out_kind_q <= room ? KIND_COUNTED : KIND_FULL;
					out_idx_q  <= room ? ENTRY_W'(new_addr) : '0;
					out_cnt_q  <= room ? COUNT_W'(1) : '0;
					out_rank_q <= '0;
					out_last_q <= 1'b1;
				end
				RES_RANK: begin
					out_kind_q <= KIND_RANKED;
					out_idx_q  <= ENTRY_W'(best_idx_q);
					out_cnt_q  <= best_q;
					out_rank_q <= RANK_OUT_W'(rank_q);
					out_last_q <= stat.rank_last;
				end
				default: begin
					out_kind_q <= KIND_FULL;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_len_q   <= '0;
			used_q      <= '0;
			scan_idx_q  <= '0;
			valid_s1    <= 1'b0;
			rank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit && (cmd.res_sel == RES_HIT || cmd.res_sel == RES_MISS)) begin
				cur_len_q <= '0;
			end else if (cmd.char_wr && (cur_len_q < LEN_W'(WORD_CHARS))) begin
				cur_len_q <= cur_len_q + LEN_W'(1);
			end
			if (row_we) begin
				used_q <= used_q + USED_W'(1);
			end
			if (cmd.scan_clr) begin
				scan_idx_q <= '0;
				valid_s1   <= 1'b0;
			end else begin
				if (issue) begin
					scan_idx_q <= scan_idx_q + USED_W'(1);
				end
				valid_s1 <= issue;
			end
			if (cmd.rank_clr) begin
				rank_q <= '0;
			end else if (cmd.rank_inc) begin
				rank_q <= rank_q + RANK_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = out_kind_q;
	assign entry_index  = out_idx_q;
	assign count        = out_cnt_q;
	assign rank         = out_rank_q;
	assign last_result  = out_last_q;

endmodule

@@ rtl/word_frequency_top_ten.sv @@
// Top level of the word frequency counter with top ten report.
//
//  channel   direction  handshake                   payload
//  item      in         item_valid / item_ready     op, word_char, last_char
//  result    out        result_valid / result_ready kind, entry_index, count, rank, last_result
//
// A word end scans the filled entries one per cycle through the registered memory
// read, stopping at the first match.
// A report runs TOP_COUNT such scans.
// Reset clears the fill count, word length, scan, rank and result valid registers; no clearing pass.
// A stalled result holds the block only when the next result must be loaded.
module word_frequency_top_ten import wft_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic                  op,
	input  logic [7:0]            word_char,
	input  logic                  last_char,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [KIND_W-1:0]     kind,
	output logic [ENTRY_W-1:0]    entry_index,
	output logic [COUNT_W-1:0]    count,
	output logic [RANK_OUT_W-1:0] rank,
	output logic                  last_result
);

	wft_cmd_t  cmd;
	wft_stat_t stat;

	wft_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.op         (op),
		.last_char  (last_char),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	wft_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.word_char    (word_char),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.kind         (kind),
		.entry_index  (entry_index),
		.count        (count),
		.rank         (rank),
		.last_result  (last_result)
	);

endmodule

@@ rtl/wft_checker.sv @@
// Port-level checks for the word frequency block, bound to the top level.
module wft_checker import wft_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_valid,
	input logic                  item_ready,
	input logic                  op,
	input logic                  last_char,
	input logic                  result_valid,
	input logic                  result_ready,
	input logic [KIND_W-1:0]     kind,
	input logic [ENTRY_W-1:0]    entry_index,
	input logic [COUNT_W-1:0]    count,
	input logic [RANK_OUT_W-1:0] rank,
	input logic                  last_result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(count) && $stable(kind))
		else $error("result changed while stalled");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_FULL |-> entry_index == '0 && count == '0 && last_result)
		else $error("ignored word carries data");

	a_counted: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_COUNTED |-> count != '0 && rank == '0 && last_result)
		else $error("counted word result malformed");

	a_rank_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_RANKED |->
			last_result == (rank == RANK_OUT_W'(TOP_COUNT - 1)))
		else $error("report end flag misplaced");

	// a word end or a report request always keeps the block busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (op == OP_REPORT || last_char) |=> !item_ready)
		else $error("request accepted while search pending");

endmodule

bind word_frequency_top_ten wft_checker u_wft_checker (.*);

@@ sim/word_frequency_top_ten_tb.sv @@
// Testbench for the word frequency counter: predicted table, ranked reports and handshake stalls.
module word_frequency_top_ten_tb import wft_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		kind_t                 kind;
		logic [ENTRY_W-1:0]    entry_index;
		logic [COUNT_W-1:0]    count;
		logic [RANK_OUT_W-1:0] rank;
		logic                  last_result;
	} tally_t;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_ready;
	logic                  op;
	logic [7:0]            word_char;
	logic                  last_char;
	logic                  result_valid;
	logic                  result_ready;
	logic [KIND_W-1:0]     kind;
	logic [ENTRY_W-1:0]    entry_index;
	logic [COUNT_W-1:0]    count;
	logic [RANK_OUT_W-1:0] rank;
	logic                  last_result;

	// predictor state
	word_row_t             known_words [MAX_WORDS];
	int unsigned           known_lens [MAX_WORDS];
	logic [COUNT_W-1:0]    word_counts [MAX_WORDS];
	int unsigned           words_used;
	word_row_t             partial_word;
	int unsigned           partial_len;

	tally_t                pending_tallies [$];
	int unsigned           mismatches;
	int unsigned           results_seen;
	int unsigned           requests_sent;
	int unsigned           full_hits;
	int unsigned           cycle_count;
	bit                    hold_off;
	bit                    stall_enable;

	word_frequency_top_ten u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.op(op), .word_char(word_char), .last_char(last_char),
		.result_valid(result_valid), .result_ready(result_ready),
		.kind(kind), .entry_index(entry_index), .count(count),
		.rank(rank), .last_result(last_result)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic void push_tally(kind_t k, int unsigned idx, logic [COUNT_W-1:0] c,
			int unsigned r, logic l);
		tally_t t;
		t.kind = k;
		t.entry_index = idx[ENTRY_W-1:0];
		t.count = c;
		t.rank = r[RANK_OUT_W-1:0];
		t.last_result = l;
		pending_tallies.push_back(t);
	endfunction

	function automatic void predict_request(logic o, logic [7:0] ch, logic lst);
		int unsigned best_idx;
		logic [COUNT_W-1:0] best;
		bit same;
		if (o == OP_REPORT) begin
			for (int j = 0; j < TOP_COUNT; j++) begin
				best = '0;
				best_idx = 0;
				for (int e = 0; e < words_used; e++)
					if (word_counts[e] > best) begin
						best = word_counts[e];
						best_idx = e;
					end
				push_tally(KIND_RANKED, best_idx, best, j, j == TOP_COUNT - 1);
				if (words_used > 0)
					word_counts[best_idx] = '0;
			end
			return;
		end
		if (partial_len < WORD_CHARS) begin
			partial_word[partial_len] = ch;
			partial_len++;
		end
		if (!lst)
			return;
		for (int e = 0; e < words_used; e++) begin
			same = known_lens[e] == partial_len;
			for (int i = 0; same && i < partial_len; i++)
				if (known_words[e][i] != partial_word[i])
					same = 0;
			if (same) begin
				if (word_counts[e] != COUNT_MAX)
					word_counts[e]++;
				push_tally(KIND_COUNTED, e, word_counts[e], 0, 1'b1);
				partial_len = 0;
				return;
			end
		end
		if (words_used < MAX_WORDS) begin
			known_words[words_used] = partial_word;
			known_lens[words_used] = partial_len;
			word_counts[words_used] = 1;
			push_tally(KIND_COUNTED, words_used, 1, 0, 1'b1);
			words_used++;
		end else begin
			push_tally(KIND_FULL, 0, 0, 0, 1'b1);
			full_hits++;
		end
		partial_len = 0;
	endfunction

	// called at a falling edge; returns at a falling edge
	task automatic send_request(logic o, logic [7:0] ch, logic lst);
		op = o;
		word_char = ch;
		last_char = lst;
		item_valid = 1'b1;
		do @(posedge clk); while (!item_ready);
		predict_request(o, ch, lst);
		requests_sent++;
		@(negedge clk);
		item_valid = 1'b0;
		op = 1'($urandom);
		word_char = 8'($urandom);
		last_char = 1'($urandom);
	endtask

	// bursts with random gaps between them
	int unsigned burst_left;
	task automatic pace();
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
		burst_left--;
	endtask

	task automatic send_word(int unsigned len, logic [7:0] base, bit vary);
		for (int i = 0; i < len; i++) begin
			pace();
			send_request(OP_CHAR, vary ? 8'($urandom) : 8'(base + i), i == len - 1);
		end
	endtask

	task automatic send_report();
		pace();
		send_request(OP_REPORT, 8'($urandom), 1'($urandom));
	endtask

	task automatic drain();
		while (pending_tallies.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_extremes();
		send_word(1, 8'h00, 0);
		send_word(1, 8'hff, 0);
		send_word(1, 8'h00, 0);
		send_word(3, 8'h55, 0);
		send_word(3, 8'haa, 0);
		send_report();
		send_report();
		drain();
	endtask

	task automatic test_overlong();
		// 65 chars then 64 chars with the same first 64: counted as one word
		send_word(WORD_CHARS + 1, 8'h10, 0);
		send_word(WORD_CHARS, 8'h10, 0);
		drain();
	endtask

	task automatic test_mid_word_report();
		pace();
		send_request(OP_CHAR, 8'h55, 1'b0);
		send_report();
		pace();
		send_request(OP_CHAR, 8'h56, 1'b0);
		pace();
		send_request(OP_CHAR, 8'h57, 1'b1);
		send_word(3, 8'h55, 0);
		drain();
	endtask

	// short words from a small alphabet so repeats are common
	task automatic test_random_traffic(int unsigned n);
		int unsigned len;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: send_report();
				1: send_word($urandom_range(1, 4), 8'h00, 1);
				default: begin
					len = $urandom_range(1, 2);
					for (int k = 0; k < len; k++) begin
						pace();
						send_request(OP_CHAR,
							8'($urandom_range(0, 2)) ^ {1'($urandom_range(0, 1)), 7'd0},
							k == len - 1);
					end
				end
			endcase
		end
		send_report();
		drain();
	endtask

	task automatic test_back_pressure();
		hold_off = 1;
		for (int i = 0; i < 12; i++)
			send_word(1, 8'h40 + 8'(i % 4), 0);
		send_report();
		hold_off = 0;
		drain();
	endtask

	// receiver stall pattern, plus the long hold-off
	initial begin
		int unsigned held;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off && held < 300) begin
				result_ready <= 1'b0;
				held++;
			end else begin
				if (!hold_off)
					held = 0;
				result_ready <= stall_enable ? (($urandom_range(0, 7) != 0) ^
					(cycle_count % 64 < 6)) : 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			tally_t want;
			results_seen++;
			if (pending_tallies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind=%0d idx=%0d count=%0d", kind, entry_index,
						count);
			end else begin
				want = pending_tallies.pop_front();
				if (kind !== want.kind || entry_index !== want.entry_index ||
						count !== want.count || rank !== want.rank ||
						last_result !== want.last_result) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp k%0d i%0d c%0d r%0d l%0d got k%0d i%0d c%0d r%0d l%0d",
							want.kind, want.entry_index, want.count, want.rank, want.last_result,
							kind, entry_index, count, rank, last_result);
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 4000000) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		op = OP_CHAR;
		word_char = '0;
		last_char = 1'b0;
		words_used = 0;
		partial_len = 0;
		partial_word = '0;
		mismatches = 0;
		results_seen = 0;
		requests_sent = 0;
		full_hits = 0;
		burst_left = 0;
		hold_off = 0;
		stall_enable = 1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_overlong();
		test_mid_word_report();
		test_random_traffic(8);
		test_back_pressure();
		repeat (200) @(posedge clk);
		$display("%0d requests sent, %0d results checked, %0d table-full words",
			requests_sent, results_seen, full_hits);
		$display("covered extremes, overlong words, mid-word reports, random words, back pressure");
		if (mismatches == 0 && pending_tallies.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
